@@ design/tbo_pkg.sv @@
// Shared types, constants and test tables for the triangle/box overlap block.
package tbo_pkg;

   // Default field widths; the payload structs are built on these
   localparam int COORD_W  = 16;
   localparam int NORMAL_W = 16;

   // Register port geometry
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Edge cross-axis tests: edge, the two projected vertices, and the
   // two box axes that make up the axis
   localparam int NUM_EDGE_TESTS = 9;
   localparam int EDGE_SEL [NUM_EDGE_TESTS] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
   localparam int P_SEL    [NUM_EDGE_TESTS] = '{0, 0, 1, 0, 0, 0, 0, 0, 1};
   localparam int Q_SEL    [NUM_EDGE_TESTS] = '{2, 2, 2, 2, 2, 1, 1, 1, 2};
   localparam int J_SEL    [NUM_EDGE_TESTS] = '{1, 2, 0, 1, 2, 0, 1, 2, 0};
   localparam int K_SEL    [NUM_EDGE_TESTS] = '{2, 0, 1, 2, 0, 1, 2, 0, 1};

   // Register map, one word apart
   typedef enum logic [2:0] {
      REG_MIN_X = 3'd0,
      REG_MIN_Y = 3'd1,
      REG_MIN_Z = 3'd2,
      REG_MAX_X = 3'd3,
      REG_MAX_Y = 3'd4,
      REG_MAX_Z = 3'd5
   } reg_idx_type;

   // First test class that separated
   typedef enum logic [1:0] {
      REJ_NONE  = 2'd0,
      REJ_EDGE  = 2'd1,
      REJ_FACE  = 2'd2,
      REJ_PLANE = 2'd3
   } rej_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  a_x;
      logic signed [COORD_W-1:0]  a_y;
      logic signed [COORD_W-1:0]  a_z;
      logic signed [COORD_W-1:0]  b_x;
      logic signed [COORD_W-1:0]  b_y;
      logic signed [COORD_W-1:0]  b_z;
      logic signed [COORD_W-1:0]  c_x;
      logic signed [COORD_W-1:0]  c_y;
      logic signed [COORD_W-1:0]  c_z;
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
   } req_type;

   typedef struct packed {
      logic    overlap;
      rej_type rejected_by;
   } rsp_type;

   // Load enables of the stages past the first
   typedef struct packed {
      logic en2;
      logic en3;
      logic en4;
   } pipe_ctl_type;

endpackage

@@ design/tbo_edge_axis.sv @@
// One edge cross-axis separation test: products, sums, then compares.
module tbo_edge_axis #(
   parameter int COORD_BITS = tbo_pkg::COORD_W
) (
   input  logic                         clock,
   input  tbo_pkg::pipe_ctl_type        ctl,
   input  logic signed [COORD_BITS:0]   e_j,
   input  logic signed [COORD_BITS:0]   e_k,
   input  logic        [COORD_BITS:0]   eabs_j,
   input  logic        [COORD_BITS:0]   eabs_k,
   input  logic signed [COORD_BITS+1:0] p_j,
   input  logic signed [COORD_BITS+1:0] p_k,
   input  logic signed [COORD_BITS+1:0] q_j,
   input  logic signed [COORD_BITS+1:0] q_k,
   input  logic signed [COORD_BITS:0]   h_j,
   input  logic signed [COORD_BITS:0]   h_k,
   output logic                         sep
);
   import tbo_pkg::*;

   localparam int MW = 2 * COORD_BITS + 3;
   localparam int SW = 2 * COORD_BITS + 5;

   logic signed [MW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [SW-1:0] pp_ff, pq_ff, rad_ff, nrad_ff;
   logic                 sep_ff;

   // Stage 2: the six products
   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         m0_ff <= MW'(e_k) * MW'(p_j);
         m1_ff <= MW'(e_j) * MW'(p_k);
         m2_ff <= MW'(e_k) * MW'(q_j);
         m3_ff <= MW'(e_j) * MW'(q_k);
         m4_ff <= MW'($signed({1'b0, eabs_k})) * MW'(h_j);
         m5_ff <= MW'($signed({1'b0, eabs_j})) * MW'(h_k);
      end
   end

   // Stage 3: projections of both vertices and the box radius
   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         pp_ff   <= SW'(m0_ff) - SW'(m1_ff);
         pq_ff   <= SW'(m2_ff) - SW'(m3_ff);
         rad_ff  <= SW'(m4_ff) + SW'(m5_ff);
         nrad_ff <= -SW'(m4_ff) - SW'(m5_ff);
      end
   end

   // Stage 4: both projections beyond the radius on one side
   always_ff @(posedge clock) begin
      if (ctl.en4) begin
         sep_ff <= (rad_ff < pp_ff && rad_ff < pq_ff) ||
                   (pp_ff < nrad_ff && pq_ff < nrad_ff);
      end
   end

   assign sep = sep_ff;

endmodule

@@ design/tbo_plane.sv @@
// Triangle plane versus box test: near/far corner dot products with the normal.
module tbo_plane #(
   parameter int COORD_BITS  = tbo_pkg::COORD_W,
   parameter int NORMAL_BITS = tbo_pkg::NORMAL_W
) (
   input  logic                          clock,
   input  tbo_pkg::pipe_ctl_type         ctl,
   input  logic signed [NORMAL_BITS-1:0] n   [3],
   input  logic signed [COORD_BITS+1:0]  dlo [3],
   input  logic signed [COORD_BITS+1:0]  dhi [3],
   output logic                          sep
);
   import tbo_pkg::*;

   localparam int PMW = NORMAL_BITS + COORD_BITS + 2;
   localparam int PSW = PMW + 2;

   logic signed [PMW-1:0] mmin_ff [3];
   logic signed [PMW-1:0] mmax_ff [3];
   logic signed [PSW-1:0] dmin_ff, dmax_ff;
   logic                  sep_ff;
   logic                  npos   [3];

   // Stage 2: pick the near and far box corner per axis, then multiply
   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         npos[ax] = !n[ax][NORMAL_BITS-1] && (n[ax] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         for (int ax = 0; ax < 3; ax++) begin
            mmin_ff[ax] <= PMW'(n[ax]) * PMW'(npos[ax] ? dlo[ax] : dhi[ax]);
            mmax_ff[ax] <= PMW'(n[ax]) * PMW'(npos[ax] ? dhi[ax] : dlo[ax]);
         end
      end
   end

   // Stage 3: dot products
   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         dmin_ff <= PSW'(mmin_ff[0]) + PSW'(mmin_ff[1]) + PSW'(mmin_ff[2]);
         dmax_ff <= PSW'(mmax_ff[0]) + PSW'(mmax_ff[1]) + PSW'(mmax_ff[2]);
      end
   end

   // Stage 4: the whole box lies on one side of the plane (signed tests via sign bit)
   always_ff @(posedge clock) begin
      if (ctl.en4) begin
         sep_ff <= (!dmin_ff[PSW-1] && (dmin_ff != '0)) || dmax_ff[PSW-1];
      end
   end

   assign sep = sep_ff;

endmodule

@@ design/triangle_box_overlap.sv @@
// Top level: triangle versus axis-aligned box overlap, pipelined.
//
// Usage: the box corners are written through the csr_ port (six registers,
// lower corner x/y/z then upper corner x/y/z, signed Q8.8, one word each);
// write them while no request is in flight. Each request on req_ carries
// one triangle (three vertices and a plane normal); each yields exactly one
// response on rsp_ with an overlap flag and the first test class that
// separated (edge cross axes, then box faces, then the triangle plane).
// The request passes the four stage datapath (prepare, multiply, sum,
// compare) and then the output register. Throughput: one request per cycle
// while rsp_stall is low. The stage valids collapse bubbles, so a request
// is still taken while a response waits, as long as some stage is empty.
// When rsp_stall is high the response holds and the pipeline fills;
// req_stall rises only when every stage and the output register hold a
// request and rsp_stall is high. Reset clears all stage valids and the box
// registers to zero; no response is presented after reset until a request
// has gone through.
module triangle_box_overlap #(
   parameter int COORD_BITS  = tbo_pkg::COORD_W,
   parameter int NORMAL_BITS = tbo_pkg::NORMAL_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tbo_pkg::req_type                     req_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tbo_pkg::rsp_type                     rsp_data,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tbo_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [tbo_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [tbo_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import tbo_pkg::*;

   localparam int EW = COORD_BITS + 1;
   localparam int WW = COORD_BITS + 2;

   // Box registers
   logic signed [COORD_BITS-1:0] box_min_ff [3];
   logic signed [COORD_BITS-1:0] box_max_ff [3];
   logic                         csr_wr;
   reg_idx_type                  csr_idx;

   // Pipeline control
   logic         v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic         en1, en5;
   pipe_ctl_type ctl;

   // Stage 1 payload
   logic signed [COORD_BITS-1:0]  vin   [3][3];
   logic signed [NORMAL_BITS-1:0] nin   [3];
   logic signed [WW-1:0]          w_ff    [3][3];
   logic signed [EW-1:0]          e_ff    [3][3];
   logic        [EW-1:0]          eabs_ff [3][3];
   logic signed [EW-1:0]          h_ff    [3];
   logic signed [NORMAL_BITS-1:0] n_ff    [3];
   logic signed [WW-1:0]          dlo_ff  [3];
   logic signed [WW-1:0]          dhi_ff  [3];

   // Face test flags down the pipe
   logic face2_in;
   logic face2_ff, face3_ff, face4_ff;

   logic [NUM_EDGE_TESTS-1:0] edge_sep;
   logic                      plane_sep;
   rsp_type                   rsp_data_in, rsp_data_ff;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ax = 0; ax < 3; ax++) begin
            box_min_ff[ax] <= '0;
            box_max_ff[ax] <= '0;
         end
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MIN_X: box_min_ff[0] <= csr_pwdata[COORD_BITS-1:0];
            REG_MIN_Y: box_min_ff[1] <= csr_pwdata[COORD_BITS-1:0];
            REG_MIN_Z: box_min_ff[2] <= csr_pwdata[COORD_BITS-1:0];
            REG_MAX_X: box_max_ff[0] <= csr_pwdata[COORD_BITS-1:0];
            REG_MAX_Y: box_max_ff[1] <= csr_pwdata[COORD_BITS-1:0];
            REG_MAX_Z: box_max_ff[2] <= csr_pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MIN_X: csr_prdata = CSR_DATA_BITS'(unsigned'(box_min_ff[0]));
         REG_MIN_Y: csr_prdata = CSR_DATA_BITS'(unsigned'(box_min_ff[1]));
         REG_MIN_Z: csr_prdata = CSR_DATA_BITS'(unsigned'(box_min_ff[2]));
         REG_MAX_X: csr_prdata = CSR_DATA_BITS'(unsigned'(box_max_ff[0]));
         REG_MAX_Y: csr_prdata = CSR_DATA_BITS'(unsigned'(box_max_ff[1]));
         REG_MAX_Z: csr_prdata = CSR_DATA_BITS'(unsigned'(box_max_ff[2]));
         default:   csr_prdata = '0;
      endcase
   end

   // ---------------- stage enables ----------------
   // A stage loads when it is empty or its successor loads
   assign en5     = !rsp_valid_ff || !rsp_stall;
   assign ctl.en4 = !v4_ff || en5;
   assign ctl.en3 = !v3_ff || ctl.en4;
   assign ctl.en2 = !v2_ff || ctl.en3;
   assign en1     = !v1_ff || ctl.en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)     v1_ff        <= req_valid;
         if (ctl.en2) v2_ff        <= v1_ff;
         if (ctl.en3) v3_ff        <= v2_ff;
         if (ctl.en4) v4_ff        <= v3_ff;
         if (en5)     rsp_valid_ff <= v4_ff;
      end
   end

   // ---------------- stage 1: box-centered vertices, edges, extents ----------------
   assign vin[0][0] = COORD_BITS'(req_data.a_x);
   assign vin[0][1] = COORD_BITS'(req_data.a_y);
   assign vin[0][2] = COORD_BITS'(req_data.a_z);
   assign vin[1][0] = COORD_BITS'(req_data.b_x);
   assign vin[1][1] = COORD_BITS'(req_data.b_y);
   assign vin[1][2] = COORD_BITS'(req_data.b_z);
   assign vin[2][0] = COORD_BITS'(req_data.c_x);
   assign vin[2][1] = COORD_BITS'(req_data.c_y);
   assign vin[2][2] = COORD_BITS'(req_data.c_z);
   assign nin[0]    = NORMAL_BITS'(req_data.normal_x);
   assign nin[1]    = NORMAL_BITS'(req_data.normal_y);
   assign nin[2]    = NORMAL_BITS'(req_data.normal_z);

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int ax = 0; ax < 3; ax++) begin
            // doubled coordinates relative to the box center
            for (int i = 0; i < 3; i++) begin
               w_ff[i][ax] <= WW'(vin[i][ax]) + WW'(vin[i][ax])
                              - WW'(box_min_ff[ax]) - WW'(box_max_ff[ax]);
            end
            // edges a->b, b->c, c->a on raw vertices
            for (int i = 0; i < 3; i++) begin
               automatic logic signed [EW-1:0] d;
               d = EW'(vin[(i + 1) % 3][ax]) - EW'(vin[i][ax]);
               e_ff[i][ax]    <= d;
               eabs_ff[i][ax] <= d[EW-1] ? unsigned'(-d) : unsigned'(d);
            end
            h_ff[ax]   <= EW'(box_max_ff[ax]) - EW'(box_min_ff[ax]);
            n_ff[ax]   <= nin[ax];
            // doubled offsets of first vertex to the box corners
            dlo_ff[ax] <= {EW'(box_min_ff[ax]) - EW'(vin[0][ax]), 1'b0};
            dhi_ff[ax] <= {EW'(box_max_ff[ax]) - EW'(vin[0][ax]), 1'b0};
         end
      end
   end

   // ---------------- edge cross-axis tests ----------------
   for (genvar t = 0; t < NUM_EDGE_TESTS; t++) begin : g_edge
      tbo_edge_axis #(
         .COORD_BITS(COORD_BITS)
      ) u_edge (
         .clock  (clock),
         .ctl    (ctl),
         .e_j    (e_ff[EDGE_SEL[t]][J_SEL[t]]),
         .e_k    (e_ff[EDGE_SEL[t]][K_SEL[t]]),
         .eabs_j (eabs_ff[EDGE_SEL[t]][J_SEL[t]]),
         .eabs_k (eabs_ff[EDGE_SEL[t]][K_SEL[t]]),
         .p_j    (w_ff[P_SEL[t]][J_SEL[t]]),
         .p_k    (w_ff[P_SEL[t]][K_SEL[t]]),
         .q_j    (w_ff[Q_SEL[t]][J_SEL[t]]),
         .q_k    (w_ff[Q_SEL[t]][K_SEL[t]]),
         .h_j    (h_ff[J_SEL[t]]),
         .h_k    (h_ff[K_SEL[t]]),
         .sep    (edge_sep[t])
      );
   end

   // ---------------- box face axes ----------------
   // Separated when all three vertices lie beyond one face
   always_comb begin
      face2_in = 1'b0;
      for (int ax = 0; ax < 3; ax++) begin
         if ((w_ff[0][ax] > WW'(h_ff[ax]) && w_ff[1][ax] > WW'(h_ff[ax]) &&
              w_ff[2][ax] > WW'(h_ff[ax])) ||
             (w_ff[0][ax] < -WW'(h_ff[ax]) && w_ff[1][ax] < -WW'(h_ff[ax]) &&
              w_ff[2][ax] < -WW'(h_ff[ax]))) begin
            face2_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) face2_ff <= face2_in;
      if (ctl.en3) face3_ff <= face2_ff;
      if (ctl.en4) face4_ff <= face3_ff;
   end

   // ---------------- triangle plane ----------------
   tbo_plane #(
      .COORD_BITS (COORD_BITS),
      .NORMAL_BITS(NORMAL_BITS)
   ) u_plane (
      .clock (clock),
      .ctl   (ctl),
      .n     (n_ff),
      .dlo   (dlo_ff),
      .dhi   (dhi_ff),
      .sep   (plane_sep)
   );

   // ---------------- response register ----------------
   always_comb begin
      if (|edge_sep) begin
         rsp_data_in.rejected_by = REJ_EDGE;
      end else if (face4_ff) begin
         rsp_data_in.rejected_by = REJ_FACE;
      end else if (plane_sep) begin
         rsp_data_in.rejected_by = REJ_PLANE;
      end else begin
         rsp_data_in.rejected_by = REJ_NONE;
      end
      rsp_data_in.overlap = (rsp_data_in.rejected_by == REJ_NONE);
   end

   always_ff @(posedge clock) begin
      if (en5) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // overlap and rejection code agree on every response
   a_overlap_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.overlap == (rsp_data_ff.rejected_by == REJ_NONE)))
      else $error("overlap flag disagrees with rejection code");

   // an open output side never back-pressures the request side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || !rsp_stall) |-> !req_stall)
      else $error("request stalled while the response side is free");

   // an accepted request occupies the first stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted request lost at stage one");

   // a held response is not dropped while stalled
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled response dropped");

   // nothing presented right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid after reset");
`endif

endmodule
